// File: rtl/srsg_pkg.sv
// ----------------------------------------------------------------------------
// srsg_pkg: shared types and constants of the ramped step generator
// Beat layouts, function and register codes, reset values and fixed widths.
// ----------------------------------------------------------------------------
package srsg_pkg;

  // Width of the step counter and of the position fields.
  localparam int POS_W = 24;
  // Default width of the elapsed-time counter.
  localparam int TIME_BITS_DEF = 24;
  // Pause length beyond the start ramp period after which the ramp restarts.
  localparam int RESTART_MARGIN_US = 1000;

  // Configuration reset values.
  localparam logic [23:0] RUN_WAIT_RST    = 24'd3000;
  localparam logic [23:0] HOMING_WAIT_RST = 24'd3000;
  localparam logic [23:0] START_RAMP_RST  = 24'd2000;
  localparam logic [15:0] RAMP_STEP_RST   = 16'd40;
  localparam logic [22:0] HOME_POS_RST    = 23'd0;
  localparam logic [22:0] END_POS_RST     = 23'd1;
  localparam logic        LIMIT_EN_RST    = 1'b0;
  localparam logic        LIMIT_LVL_RST   = 1'b1;
  localparam logic [23:0] RAMP_PERIOD_RST = 24'd3000;

  typedef enum logic [1:0] {
    FUNC_IDLE  = 2'd0,
    FUNC_MOVE  = 2'd1,
    FUNC_HOME  = 2'd2,
    FUNC_ABORT = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_RUN_WAIT    = 3'd0,
    REG_HOMING_WAIT = 3'd1,
    REG_START_RAMP  = 3'd2,
    REG_RAMP_STEP   = 3'd3,
    REG_HOME_POS    = 3'd4,
    REG_END_POS     = 3'd5,
    REG_LIMIT_EN    = 3'd6,
    REG_LIMIT_LVL   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_SEEK   = 3'b010,
    PH_RETURN = 3'b100
  } phase_t;

  // Encoded homing stage as reported on the result channel.
  localparam logic [1:0] STAGE_IDLE   = 2'd0;
  localparam logic [1:0] STAGE_SEEK   = 2'd1;
  localparam logic [1:0] STAGE_RETURN = 2'd2;

  typedef struct packed {
    func_t                    func;
    logic signed [POS_W-1:0]  target_position;
    logic                     limit_level;
  } in_item_t;

  typedef struct packed {
    logic                     step_pulse;
    logic                     forward_dir;
    logic signed [POS_W-1:0]  position;
    logic                     at_target;
    logic                     homing_done;
    logic [1:0]               homing_stage;
  } out_item_t;

endpackage

// File: rtl/stepper_ramped_step_generator.sv
// ----------------------------------------------------------------------------
// stepper_ramped_step_generator: stepper step generator with linear start ramp
// Turns each tick beat into one step/direction/status result beat.
// ----------------------------------------------------------------------------
// Usage
//   Each input beat on in_* stands for one microsecond tick and carries the
//   function code (idle, move toward target, homing tick, homing abort), the
//   requested target and the sampled limit switch level. Each accepted tick
//   yields exactly one result beat on out_*: the step pulse, the direction,
//   the position after the tick and the move/homing status.
//   An accepted tick's result beat is registered and shows from the next
//   cycle on. Throughput is one tick per cycle while results drain, set by
//   the single registered pass from the stored state and the input beat
//   into the result register; the state registers update at the same edge.
//   When the receiver stalls, the result beat holds in the output register
//   and in_ready drops, so no tick is taken until the result is drained; a
//   result taken in the same cycle frees the slot for a new tick.
//   The APB-style port (pready always high) holds eight 32-bit registers at
//   byte addresses 4*i and should be written only while the block is idle.
//   A synchronous low rst_n restores all registers to their defaults, clears
//   the step count and the timer, and empties the output register.
// ----------------------------------------------------------------------------
module stepper_ramped_step_generator
  import srsg_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Comparisons of time values run at a width that holds both the timer and
  // the restart threshold (a 24-bit period plus the margin).
  localparam int CMP_W = (TIME_BITS > 25) ? TIME_BITS : 25;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Configuration registers.
  logic [23:0]      run_wait_r, homing_wait_r, start_ramp_r;
  logic [15:0]      ramp_step_r;
  logic [22:0]      home_pos_r, end_pos_r;
  logic             limit_en_r, limit_lvl_r;

  // Generator state.
  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [POS_W-1:0]     step_r, step_nxt;
  logic                 dir_r, dir_nxt;
  logic                 dc_r, dc_nxt;
  logic                 ra_r, ra_nxt;
  logic [23:0]          rp_r, rp_nxt;
  phase_t               phase_r, phase_nxt;
  logic [POS_W-1:0]     target_r, target_nxt;

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  // Per-tick working values.
  logic                 accept;
  logic                 cfg_wr;
  logic [TIME_BITS-1:0] el;
  logic [CMP_W-1:0]     el_x, wait_x, start_x, thresh_x;
  logic [23:0]          wait_sel;
  logic                 call, go, pulse, at, done, lim_act;
  logic [POS_W-1:0]     tclamp;
  logic [POS_W:0]       t_x, home_x, end_x;
  logic [POS_W:0]       d0, d1, a0, a1;
  logic [1:0]           stage;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  // A tick is taken whenever the output slot is empty or being drained.
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register reads.
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_RUN_WAIT:    prdata = {8'd0, run_wait_r};
      REG_HOMING_WAIT: prdata = {8'd0, homing_wait_r};
      REG_START_RAMP:  prdata = {8'd0, start_ramp_r};
      REG_RAMP_STEP:   prdata = {16'd0, ramp_step_r};
      REG_HOME_POS:    prdata = {9'd0, home_pos_r};
      REG_END_POS:     prdata = {9'd0, end_pos_r};
      REG_LIMIT_EN:    prdata = {31'd0, limit_en_r};
      REG_LIMIT_LVL:   prdata = {31'd0, limit_lvl_r};
      default:         prdata = '0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_wait_r    <= RUN_WAIT_RST;
      homing_wait_r <= HOMING_WAIT_RST;
      start_ramp_r  <= START_RAMP_RST;
      ramp_step_r   <= RAMP_STEP_RST;
      home_pos_r    <= HOME_POS_RST;
      end_pos_r     <= END_POS_RST;
      limit_en_r    <= LIMIT_EN_RST;
      limit_lvl_r   <= LIMIT_LVL_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_RUN_WAIT:    run_wait_r    <= pwdata[23:0];
        REG_HOMING_WAIT: homing_wait_r <= pwdata[23:0];
        REG_START_RAMP:  start_ramp_r  <= pwdata[23:0];
        REG_RAMP_STEP:   ramp_step_r   <= pwdata[15:0];
        REG_HOME_POS:    home_pos_r    <= pwdata[22:0];
        REG_END_POS:     end_pos_r     <= pwdata[22:0];
        REG_LIMIT_EN:    limit_en_r    <= pwdata[0];
        REG_LIMIT_LVL:   limit_lvl_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // One tick of the generator. The steps below follow the order in which the
  // state is touched: timer, function decode, shared ramp/step unit, and the
  // move reversal that looks at the step just taken.
  always_comb begin
    // The timer counts this tick first and saturates.
    el = elapsed_r;
    if (elapsed_r != TIME_MAX) begin
      el = elapsed_r + 1'b1;
    end

    elapsed_nxt = el;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    dc_nxt      = dc_r;
    ra_nxt      = ra_r;
    rp_nxt      = rp_r;
    phase_nxt   = phase_r;
    target_nxt  = target_r;
    pulse       = 1'b0;
    at          = 1'b0;
    done        = 1'b0;
    call        = 1'b0;
    go          = 1'b0;
    wait_sel    = run_wait_r;

    lim_act = (in_data.limit_level == limit_lvl_r);

    // Clamp the target into the workspace. The low bound is checked first,
    // so a home past the end still wins.
    t_x    = {in_data.target_position[POS_W-1], in_data.target_position};
    home_x = (POS_W+1)'(home_pos_r);
    end_x  = (POS_W+1)'(end_pos_r);
    if ($signed(t_x) < $signed(home_x)) begin
      tclamp = POS_W'(home_x + 1'b1);
    end else if ($signed(t_x) > $signed(end_x)) begin
      tclamp = POS_W'(end_x - 1'b1);
    end else begin
      tclamp = in_data.target_position;
    end

    case (in_data.func)
      FUNC_MOVE: begin
        target_nxt = tclamp;
        wait_sel   = run_wait_r;
        call       = (tclamp != step_r);
        at         = (tclamp == step_r);
      end
      FUNC_HOME: begin
        wait_sel = homing_wait_r;
        if (phase_r == PH_IDLE) begin
          // Start seeking the limit: turn backward.
          phase_nxt = PH_SEEK;
          dc_nxt    = dir_r;
          dir_nxt   = 1'b0;
        end
        case (phase_nxt)
          PH_SEEK: begin
            if (!(lim_act && (step_r == '0))) begin
              call = 1'b1;
            end else begin
              dc_nxt    = !dir_nxt;
              dir_nxt   = 1'b1;
              phase_nxt = PH_RETURN;
            end
          end
          PH_RETURN: begin
            if (step_r != POS_W'(home_x)) begin
              call = 1'b1;
            end else begin
              phase_nxt  = PH_IDLE;
              target_nxt = POS_W'(home_x);
              done       = 1'b1;
            end
          end
          default: ;
        endcase
      end
      FUNC_ABORT: begin
        phase_nxt = PH_IDLE;
      end
      default: ;
    endcase

    // Shared ramp and step unit, run for the active period.
    el_x     = CMP_W'(el);
    wait_x   = CMP_W'(wait_sel);
    start_x  = CMP_W'(start_ramp_r);
    thresh_x = CMP_W'(start_ramp_r) + CMP_W'(RESTART_MARGIN_US);
    if (call && (el_x >= wait_x)) begin
      go = 1'b1;
      if (wait_x < start_x) begin
        // Restart the ramp after a long pause or a reversal.
        if ((el_x > thresh_x) || dc_nxt) begin
          ra_nxt = 1'b1;
          dc_nxt = 1'b0;
          rp_nxt = start_ramp_r;
        end
      end else begin
        ra_nxt = 1'b0;
      end
      if (ra_nxt) begin
        if (el_x < CMP_W'(rp_nxt)) begin
          go = 1'b0;
        end else begin
          if (rp_nxt > 24'(ramp_step_r)) begin
            rp_nxt = rp_nxt - 24'(ramp_step_r);
          end else begin
            rp_nxt = '0;
          end
          if (rp_nxt <= wait_sel) begin
            ra_nxt = 1'b0;
            rp_nxt = wait_sel;
          end
        end
      end else begin
        rp_nxt = wait_sel;
      end
      if (go && limit_en_r) begin
        if (lim_act) begin
          step_nxt = '0;
          if (!dir_nxt) begin
            go = 1'b0;
          end
        end
        if (go && dir_nxt && (step_nxt == POS_W'(end_x))) begin
          go = 1'b0;
        end
      end
      if (go) begin
        step_nxt    = dir_nxt ? step_nxt + 1'b1 : step_nxt - 1'b1;
        elapsed_nxt = '0;
        pulse       = 1'b1;
      end
    end

    // A move reverses only when the step moved away from the target.
    d0 = {target_nxt[POS_W-1], target_nxt} - {step_r[POS_W-1], step_r};
    d1 = {target_nxt[POS_W-1], target_nxt} - {step_nxt[POS_W-1], step_nxt};
    a0 = d0[POS_W] ? (~d0 + 1'b1) : d0;
    a1 = d1[POS_W] ? (~d1 + 1'b1) : d1;
    if ((in_data.func == FUNC_MOVE) && call && (a0 < a1)) begin
      dc_nxt  = 1'b1;
      dir_nxt = !dir_nxt;
    end

    case (phase_nxt)
      PH_IDLE:   stage = STAGE_IDLE;
      PH_SEEK:   stage = STAGE_SEEK;
      PH_RETURN: stage = STAGE_RETURN;
      default:   stage = STAGE_IDLE;
    endcase

    out_data_nxt.step_pulse   = pulse;
    out_data_nxt.forward_dir  = dir_nxt;
    out_data_nxt.position     = step_nxt;
    out_data_nxt.at_target    = at;
    out_data_nxt.homing_done  = done;
    out_data_nxt.homing_stage = stage;
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      step_r      <= '0;
      dir_r       <= 1'b1;
      dc_r        <= 1'b0;
      ra_r        <= 1'b1;
      rp_r        <= RAMP_PERIOD_RST;
      phase_r     <= PH_IDLE;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        elapsed_r   <= elapsed_nxt;
        step_r      <= step_nxt;
        dir_r       <= dir_nxt;
        dc_r        <= dc_nxt;
        ra_r        <= ra_nxt;
        rp_r        <= rp_nxt;
        phase_r     <= phase_nxt;
        target_r    <= target_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The result payload carries no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/srsg_checker.sv
// ----------------------------------------------------------------------------
// srsg_checker: port-level checks of the ramped step generator
// Watches the tick and result channels and the status fields over time.
// ----------------------------------------------------------------------------
module srsg_checker
  import srsg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed or dropped while stalled");

  // With an empty output slot the block must take a tick.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("tick refused with an empty output slot");

  // Every accepted tick shows a result beat in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result beat");

  // Homing done comes with no step, no at_target and the idle stage.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.homing_done |->
      (out_data.homing_stage == STAGE_IDLE) && !out_data.step_pulse
      && !out_data.at_target)
    else $error("homing done with a step or a live homing stage");

endmodule

bind stepper_ramped_step_generator srsg_checker u_srsg_checker (.*);

// File: tb/stepper_ramped_step_generator_tb.sv
// ----------------------------------------------------------------------------
// stepper_ramped_step_generator_tb: self-checking bench for the step generator
// Drives tick beats with random gaps and result stalls and reprograms the
// registers between phases. A tick-level model predicts every result beat,
// and each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stepper_ramped_step_generator_tb;
  import srsg_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam longint TICK_MAX    = longint'((64'd1 << TIME_BITS_DEF) - 1);

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stepper_ramped_step_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copies of the configuration registers, as the block holds them.
  longint sh_run_wait;
  longint sh_homing_wait;
  longint sh_start_ramp;
  longint sh_ramp_step;
  longint sh_home_pos;
  longint sh_end_pos;
  logic   sh_limit_en;
  logic   sh_limit_lvl;

  // State of the step model: time since the last step, the step counter,
  // the direction and its change flag, the ramp, the homing stage and the
  // stored target.
  longint     tick_age;
  longint     pos_cnt;
  bit         fwd;
  bit         turned;
  bit         ramping;
  longint     ramp_wait;
  logic [1:0] home_stage;
  longint     goal;

  // Predicted result beats, oldest first.
  out_item_t pending_results[$];

  int mismatches;
  int sent_count;
  int result_count;
  int cycle_count;

  // Stimulus pacing: the sender idles before a beat with odds of one in
  // gap_odds (zero means never), and the receiver stalls only when stall_on.
  int gap_odds;
  bit stall_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Step model
  // --------------------------------------------------------------------------

  function automatic longint wrap24(longint v);
    logic signed [POS_W-1:0] u;
    u = v[POS_W-1:0];
    return u;
  endfunction

  function automatic void turn_to(bit dir);
    turned = (fwd != dir);
    fwd    = dir;
  endfunction

  // Issues a step when the active period and the ramp allow it. The ramp is
  // only used when the period is shorter than the start ramp period, and it
  // restarts after a long pause or a reversal. If enabled, the limit switch
  // zeroes the count and blocks backward steps, the end position forward ones.
  function automatic bit step_if_due(longint period, logic lim);
    longint el;
    el = tick_age;
    if (el < period) return 1'b0;
    if (period < sh_start_ramp) begin
      if (el > sh_start_ramp + RESTART_MARGIN_US || turned) begin
        ramping   = 1'b1;
        turned    = 1'b0;
        ramp_wait = sh_start_ramp;
      end
    end else begin
      ramping = 1'b0;
    end
    if (ramping) begin
      if (el < ramp_wait) return 1'b0;
      // A reduction past zero saturates, and the ramp then ends.
      ramp_wait = (ramp_wait > sh_ramp_step) ? ramp_wait - sh_ramp_step : 0;
      if (ramp_wait <= period) begin
        ramping   = 1'b0;
        ramp_wait = period;
      end
    end else begin
      ramp_wait = period;
    end
    if (sh_limit_en) begin
      if (lim == sh_limit_lvl) begin
        pos_cnt = 0;
        if (!fwd) return 1'b0;
      end
      if (pos_cnt == sh_end_pos && fwd) return 1'b0;
    end
    pos_cnt  = wrap24(pos_cnt + (fwd ? 1 : -1));
    tick_age = 0;
    return 1'b1;
  endfunction

  // Works out the result beat of one tick and advances the model state.
  function automatic void advance_tick(input in_item_t it, output out_item_t r);
    longint t;
    longint d0;
    longint d1;
    bit     pulse;
    bit     at;
    bit     done;
    pulse = 1'b0;
    at    = 1'b0;
    done  = 1'b0;
    if (tick_age < TICK_MAX) tick_age++;
    case (it.func)
      FUNC_MOVE: begin
        // The target is clamped just inside the workspace.
        t = $signed(it.target_position);
        if (t < sh_home_pos) t = sh_home_pos + 1;
        else if (t > sh_end_pos) t = sh_end_pos - 1;
        goal = wrap24(t);
        d0 = goal - pos_cnt;
        if (d0 != 0) begin
          pulse = step_if_due(sh_run_wait, it.limit_level);
          d1 = goal - pos_cnt;
          if (d0 < 0) d0 = -d0;
          if (d1 < 0) d1 = -d1;
          // Only a step that moved away from the target reverses.
          if (d0 < d1) turn_to(!fwd);
        end else begin
          at = 1'b1;
        end
      end
      FUNC_HOME: begin
        if (home_stage == STAGE_IDLE) begin
          home_stage = STAGE_SEEK;
          turn_to(1'b0);
        end
        if (home_stage == STAGE_SEEK) begin
          if (!(it.limit_level == sh_limit_lvl && pos_cnt == 0)) begin
            pulse = step_if_due(sh_homing_wait, it.limit_level);
          end else begin
            turn_to(1'b1);
            home_stage = STAGE_RETURN;
          end
        end else if (home_stage == STAGE_RETURN) begin
          if (pos_cnt != sh_home_pos) begin
            pulse = step_if_due(sh_homing_wait, it.limit_level);
          end else begin
            home_stage = STAGE_IDLE;
            goal       = wrap24(sh_home_pos);
            done       = 1'b1;
          end
        end
      end
      FUNC_ABORT: home_stage = STAGE_IDLE;
      default: ;
    endcase
    r.step_pulse   = pulse;
    r.forward_dir  = fwd;
    r.position     = pos_cnt[POS_W-1:0];
    r.at_target    = at;
    r.homing_done  = done;
    r.homing_stage = home_stage;
  endfunction

  function automatic void reset_model();
    sh_run_wait    = RUN_WAIT_RST;
    sh_homing_wait = HOMING_WAIT_RST;
    sh_start_ramp  = START_RAMP_RST;
    sh_ramp_step   = RAMP_STEP_RST;
    sh_home_pos    = HOME_POS_RST;
    sh_end_pos     = END_POS_RST;
    sh_limit_en    = LIMIT_EN_RST;
    sh_limit_lvl   = LIMIT_LVL_RST;
    tick_age       = 0;
    pos_cnt        = 0;
    fwd            = 1'b1;
    turned         = 1'b0;
    ramping        = 1'b1;
    ramp_wait      = RAMP_PERIOD_RST;
    home_stage     = STAGE_IDLE;
    goal           = 0;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic flag_error(string msg);
    $display("mismatch at result %0d: %s", result_count, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Every result beat taken at a rising edge is matched against the oldest
  // prediction. A beat with nothing predicted is an error by itself.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result beat with no prediction waiting");
      end else begin
        want = pending_results.pop_front();
        compare_field("step_pulse", out_data.step_pulse, want.step_pulse);
        compare_field("forward_dir", out_data.forward_dir, want.forward_dir);
        compare_field("position", out_data.position, want.position);
        compare_field("at_target", out_data.at_target, want.at_target);
        compare_field("homing_done", out_data.homing_done, want.homing_done);
        compare_field("homing_stage", out_data.homing_stage, want.homing_stage);
      end
      result_count++;
    end
  end

  // The run is stopped when it takes far longer than the slowest correct run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // The receiver runs in bursts, each ready or stalled at random. Once
  // stall_on is cleared it stays ready after the current burst.
  initial begin : result_sink
    int left;
    bit hold;
    left      = 0;
    hold      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        hold = stall_on && ($urandom_range(0, 1) == 1);
        left = $urandom_range(1, 12);
      end
      left--;
      out_ready = !hold;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end at a falling edge.
  // --------------------------------------------------------------------------

  // Sends one tick beat. The beat is held until it is taken, and the model is
  // stepped at the edge that takes it. Valid stays high on return so that a
  // following beat can go out back to back.
  task automatic send_tick(in_item_t it);
    out_item_t r;
    int        gap;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    advance_tick(it, r);
    pending_results.push_back(r);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic in_item_t make_tick(func_t f, logic [POS_W-1:0] tgt, logic lim);
    in_item_t it;
    it.func            = f;
    it.target_position = tgt;
    it.limit_level     = lim;
    return it;
  endfunction

  function automatic logic switch_level(bit active);
    return active ? sh_limit_lvl : !sh_limit_lvl;
  endfunction

  // Holds off the sender until every predicted result has come out, then
  // lets the result register settle.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes one register through a setup and an access cycle, only with the
  // block idle. The shadow copy is updated at the edge that writes it.
  task automatic write_reg(reg_idx_t idx, longint val);
    logic [31:0] word;
    word = val[31:0];
    wait_drained();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = word;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RUN_WAIT:    sh_run_wait    = word[23:0];
      REG_HOMING_WAIT: sh_homing_wait = word[23:0];
      REG_START_RAMP:  sh_start_ramp  = word[23:0];
      REG_RAMP_STEP:   sh_ramp_step   = word[15:0];
      REG_HOME_POS:    sh_home_pos    = word[22:0];
      REG_END_POS:     sh_end_pos     = word[22:0];
      REG_LIMIT_EN:    sh_limit_en    = word[0];
      REG_LIMIT_LVL:   sh_limit_lvl   = word[0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // A run of move ticks toward a target mostly near the workspace, now and
  // then far outside it. At or below step zero the switch is often active.
  task automatic move_run(int len);
    longint tgt;
    bit     act;
    tgt = 0;
    for (int i = 0; i < len; i++) begin
      if (i == 0 || $urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 4) == 0) tgt = $signed($urandom() & 32'hFF_FFFF) <<< 8 >>> 8;
        else tgt = sh_home_pos - 2 + $urandom_range(0, sh_end_pos - sh_home_pos + 4);
      end
      act = (pos_cnt <= 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 19) == 0);
      send_tick(make_tick(FUNC_MOVE, tgt[POS_W-1:0], switch_level(act)));
    end
  endtask

  // A homing sequence: the switch closes once the count reaches zero, with a
  // little noise, and the sequence now and then is cut off by an abort.
  task automatic homing_run(int max_len);
    bit act;
    for (int i = 0; i < max_len; i++) begin
      if (i > 0 && home_stage == STAGE_IDLE) break;
      if ($urandom_range(0, 39) == 0) begin
        send_tick(make_tick(FUNC_ABORT, $urandom(), $urandom_range(0, 1)));
        break;
      end
      act = (pos_cnt <= 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
      send_tick(make_tick(FUNC_HOME, $urandom(), switch_level(act)));
    end
  endtask

  task automatic idle_run(int len);
    for (int i = 0; i < len; i++) begin
      send_tick(make_tick(FUNC_IDLE, $urandom(), $urandom_range(0, 1)));
    end
  endtask

  // Short periods keep steps frequent; the limit switch is usually fitted so
  // that homing can complete.
  task automatic randomize_config();
    longint home;
    home = $urandom_range(0, 8);
    write_reg(REG_RUN_WAIT, $urandom_range(0, 6));
    write_reg(REG_HOMING_WAIT, $urandom_range(0, 6));
    write_reg(REG_START_RAMP, $urandom_range(1, 40));
    write_reg(REG_RAMP_STEP, $urandom_range(0, 10));
    write_reg(REG_HOME_POS, home);
    if ($urandom_range(0, 7) == 0) write_reg(REG_END_POS, $urandom_range(0, 8));
    else write_reg(REG_END_POS, home + $urandom_range(0, 30));
    write_reg(REG_LIMIT_EN, $urandom_range(0, 3) != 0);
    write_reg(REG_LIMIT_LVL, $urandom_range(0, 1));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With the reset settings: an idle tick, moves whose clamped target is the
  // current position or one step off, a homing pass that completes at once
  // because the switch is closed at step zero, and an abort.
  task automatic test_reset_defaults();
    send_tick(make_tick(FUNC_IDLE, '0, 1'b0));
    send_tick(make_tick(FUNC_MOVE, 24'd0, 1'b0));
    send_tick(make_tick(FUNC_MOVE, 24'd100, 1'b0));
    send_tick(make_tick(FUNC_MOVE, -24'sd5, 1'b0));
    send_tick(make_tick(FUNC_HOME, '0, 1'b1));
    send_tick(make_tick(FUNC_HOME, '0, 1'b1));
    send_tick(make_tick(FUNC_HOME, '0, 1'b0));
    send_tick(make_tick(FUNC_ABORT, '0, 1'b0));
  endtask

  // Register extremes. A home position at the top of the range clamps a low
  // target to a value that wraps to the most negative step number.
  task automatic test_register_extremes();
    write_reg(REG_RUN_WAIT, 24'hFF_FFFF);
    write_reg(REG_HOMING_WAIT, 24'hFF_FFFF);
    write_reg(REG_START_RAMP, 24'hFF_FFFF);
    write_reg(REG_RAMP_STEP, 16'hFFFF);
    write_reg(REG_HOME_POS, 23'h7F_FFFF);
    write_reg(REG_END_POS, 23'h7F_FFFF);
    send_tick(make_tick(FUNC_MOVE, 24'h80_0000, 1'b0));
    send_tick(make_tick(FUNC_MOVE, 24'h7F_FFFF, 1'b1));
    send_tick(make_tick(FUNC_HOME, 24'hFF_FFFF, 1'b0));
    send_tick(make_tick(FUNC_ABORT, 24'hFF_FFFF, 1'b1));
    write_reg(REG_HOME_POS, 0);
    write_reg(REG_END_POS, 0);
    send_tick(make_tick(FUNC_MOVE, 24'd5, 1'b0));
  endtask

  // A zero period and a ramp whose reduction runs below zero, then a pause
  // longer than the restart margin so that the ramp starts over.
  task automatic test_ramp_and_pause();
    write_reg(REG_RUN_WAIT, 0);
    write_reg(REG_START_RAMP, 3);
    write_reg(REG_RAMP_STEP, 16'hFFFF);
    write_reg(REG_END_POS, 20);
    send_tick(make_tick(FUNC_MOVE, 24'd12, 1'b0));
    send_tick(make_tick(FUNC_MOVE, 24'd12, 1'b0));
    send_tick(make_tick(FUNC_MOVE, -24'sd3, 1'b0));
    send_tick(make_tick(FUNC_MOVE, -24'sd3, 1'b0));
    write_reg(REG_RUN_WAIT, 1);
    write_reg(REG_RAMP_STEP, 1);
    move_run(6);
    idle_run(sh_start_ramp + RESTART_MARGIN_US + 8);
    move_run(8);
  endtask

  // With the switch fitted at active-low level: the end position blocks a
  // forward step, and an active switch zeroes the count and blocks backward.
  task automatic test_limit_switch();
    write_reg(REG_LIMIT_EN, 1);
    write_reg(REG_LIMIT_LVL, 0);
    write_reg(REG_START_RAMP, 1);
    write_reg(REG_END_POS, 4);
    for (int i = 0; i < 5; i++) send_tick(make_tick(FUNC_MOVE, 24'd3, 1'b1));
    write_reg(REG_END_POS, pos_cnt);
    for (int i = 0; i < 3; i++) send_tick(make_tick(FUNC_MOVE, 24'd0, 1'b1));
    for (int i = 0; i < 3; i++) send_tick(make_tick(FUNC_MOVE, 24'd0, 1'b0));
  endtask

  // Full homing passes: seek the switch, return to home and flag done.
  task automatic test_homing();
    write_reg(REG_LIMIT_LVL, 1);
    write_reg(REG_HOME_POS, 3);
    write_reg(REG_END_POS, 10);
    write_reg(REG_HOMING_WAIT, 1);
    write_reg(REG_START_RAMP, 4);
    move_run(20);
    homing_run(120);
    homing_run(120);
  endtask

  // Random phases, each with fresh settings. Most traffic is well-formed move
  // and homing sequences; the rest is idle runs and single beats of any
  // function with random content. The last phase has no gaps or stalls.
  task automatic test_random_traffic();
    int first;
    int kind;
    for (int p = 0; p < 6; p++) begin
      stall_on = (p != 5);
      gap_odds = (p == 5) ? 0 : ((p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8));
      randomize_config();
      first = sent_count;
      while (sent_count - first < 20) begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) move_run($urandom_range(5, 40));
        else if (kind <= 5) homing_run($urandom_range(20, 120));
        else if (kind == 6) idle_run($urandom_range(1, 20));
        else send_tick(make_tick(func_t'($urandom_range(0, 3)), $urandom(),
                                 $urandom_range(0, 1)));
        // Now and then the sender waits for the block to drain completely.
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    sent_count   = 0;
    result_count = 0;
    gap_odds     = 4;
    stall_on     = 1'b1;
    reset_model();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_ramp_and_pause();
    test_limit_switch();
    test_homing();
    test_random_traffic();

    // Let every result come out, then watch for a stray beat.
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/srsg_pkg.sv
rtl/stepper_ramped_step_generator.sv
rtl/srsg_checker.sv
tb/stepper_ramped_step_generator_tb.sv
